@@ hw/rtl/rmf_pkg.sv @@
// Package for the message fragmenter: channel payload types, the word held
// between the sequencer and the emitter, and fixed header constants.
// Depends on nothing.
package rmf_pkg;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        msg_start;
      logic [31:0] msg_length;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        packet_first;
      logic        packet_last;
      logic        fragment_flag;
      logic [15:0] packet_seq;
      logic        message_last;
   } rsp_payload_type;

   localparam logic [2:0] HDR_NONE    = 3'd0;
   localparam logic [2:0] HDR_SEQ     = 3'd2;
   localparam logic [2:0] HDR_SEQ_LEN = 3'd6;

   localparam logic [15:0] MAX_LEN_RESET  = 16'd512;
   localparam logic [15:0] MIN_PACKET_LEN = 16'd7;
   localparam logic [15:0] SEQ_HDR_BYTES  = 16'd2;
   localparam logic [15:0] FULL_HDR_BYTES = 16'd6;

   typedef struct packed {
      logic [2:0]  hdr_count;
      logic [15:0] seq;
      logic        frag;
      logic [31:0] msg_total;
      logic [7:0]  data;
      logic        pkt_last;
      logic        msg_last;
   } job_type;

endpackage

@@ hw/rtl/rmf_channels.sv @@
// Valid/ready channel interfaces for the message fragmenter.
// Depends on rmf_pkg for the payload types.
interface rmf_req_if import rmf_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rmf_rsp_if import rmf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/rmf_sequencer.sv @@
// Message and packet bookkeeping: accepts input words, updates the sequence,
// length and room state, and holds one job word for the emitter.
// Depends on rmf_pkg and rmf_req_if.
module rmf_sequencer import rmf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rmf_req_if.sink      req_chan,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data,
   input  logic         job_pop,
   output logic         job_valid,
   output job_type      job
);

   logic [15:0] max_len_ff, max_len_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] left_ff, left_in;
   logic [15:0] room_ff, room_in;
   logic        frag_ff, frag_in;
   logic        open_ff, open_in;
   logic        job_valid_ff, job_valid_in;
   job_type     job_ff, job_in;

   logic [15:0] max_eff;
   logic        accept;
   logic        active;
   logic [2:0]  hdr;
   logic [31:0] left_w, left_d;
   logic [15:0] room_w, room_d;
   logic [15:0] seq_w;
   logic        frag_w, open_w;
   logic        msg_last, pkt_last;

   assign req_chan.ready = !job_valid_ff || job_pop;
   assign accept = req_chan.valid && req_chan.ready;
   assign job_valid = job_valid_ff;
   assign job = job_ff;

   always_comb begin
      max_eff = (max_len_ff < MIN_PACKET_LEN) ? MIN_PACKET_LEN : max_len_ff;
      left_w = left_ff;
      room_w = room_ff;
      frag_w = frag_ff;
      open_w = open_ff;
      hdr = HDR_NONE;
      active = 1'b0;
      if (req_chan.payload.msg_start) begin
         left_w = req_chan.payload.msg_length;
         open_w = 1'b0;
         room_w = 16'd0;
         frag_w = 1'b0;
         if (req_chan.payload.msg_length != 32'd0) begin
            active = 1'b1;
            frag_w = req_chan.payload.msg_length > {16'd0, max_eff - SEQ_HDR_BYTES};
            room_w = frag_w ? (max_eff - FULL_HDR_BYTES) : (max_eff - SEQ_HDR_BYTES);
            hdr = frag_w ? HDR_SEQ_LEN : HDR_SEQ;
         end
      end else if (left_ff != 32'd0) begin
         active = 1'b1;
         if (!open_ff) begin
            room_w = max_eff - SEQ_HDR_BYTES;
            hdr = HDR_SEQ;
         end
      end
      seq_w = seq_ff;
      if (hdr != HDR_NONE) begin
         seq_w = seq_ff + 16'd1;
         open_w = 1'b1;
      end
      left_d = left_w - 32'd1;
      room_d = (room_w != 16'd0) ? (room_w - 16'd1) : 16'd0;
      msg_last = (left_d == 32'd0);
      pkt_last = msg_last || (room_d == 16'd0);

      job_in.hdr_count = hdr;
      job_in.seq = seq_w - 16'd1;
      job_in.frag = frag_w;
      job_in.msg_total = req_chan.payload.msg_length;
      job_in.data = req_chan.payload.data_byte;
      job_in.pkt_last = pkt_last;
      job_in.msg_last = msg_last;

      seq_in = seq_ff;
      left_in = left_ff;
      room_in = room_ff;
      frag_in = frag_ff;
      open_in = open_ff;
      job_valid_in = job_valid_ff && !job_pop;
      if (accept) begin
         seq_in = seq_w;
         if (active) begin
            left_in = left_d;
            room_in = pkt_last ? 16'd0 : room_d;
            open_in = open_w && !pkt_last;
            frag_in = frag_w && !msg_last;
            job_valid_in = 1'b1;
         end else begin
            left_in = left_w;
            room_in = room_w;
            open_in = open_w;
            frag_in = frag_w;
            job_valid_in = 1'b0;
         end
      end
      max_len_in = csr_write_enable ? csr_write_data : max_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         seq_ff <= 16'd0;
         left_ff <= 32'd0;
         room_ff <= 16'd0;
         frag_ff <= 1'b0;
         open_ff <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         max_len_ff <= max_len_in;
         seq_ff <= seq_in;
         left_ff <= left_in;
         room_ff <= room_in;
         frag_ff <= frag_in;
         open_ff <= open_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

@@ hw/rtl/rmf_emitter.sv @@
// Serializes one job word into header and payload words through an output
// register. Depends on rmf_pkg and rmf_rsp_if.
module rmf_emitter import rmf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  job,
   output logic     job_pop,
   rmf_rsp_if.source rsp_chan
);

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic [2:0]      idx_ff, idx_in;
   logic            load;
   logic            at_data;

   assign load = job_valid && (!out_valid_ff || rsp_chan.ready);
   assign at_data = (idx_ff == job.hdr_count);
   assign job_pop = load && at_data;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_comb begin
      out_in.packet_first = 1'b0;
      out_in.packet_last = 1'b0;
      out_in.message_last = 1'b0;
      out_in.fragment_flag = job.frag;
      out_in.packet_seq = job.seq;
      if (at_data) begin
         out_in.out_byte = job.data;
         out_in.packet_last = job.pkt_last;
         out_in.message_last = job.msg_last;
      end else begin
         case (idx_ff)
            3'd0: begin
               out_in.out_byte = job.seq[15:8];
               out_in.packet_first = 1'b1;
            end
            3'd1: out_in.out_byte = job.seq[7:0];
            3'd2: out_in.out_byte = job.msg_total[31:24];
            3'd3: out_in.out_byte = job.msg_total[23:16];
            3'd4: out_in.out_byte = job.msg_total[15:8];
            default: out_in.out_byte = job.msg_total[7:0];
         endcase
      end
      idx_in = idx_ff;
      if (load) begin
         idx_in = at_data ? 3'd0 : (idx_ff + 3'd1);
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ hw/rtl/reliable_message_fragmenter.sv @@
// Top level of the sequenced message fragmenter.
// Depends on rmf_pkg, rmf_channels, rmf_sequencer and rmf_emitter.
//
// Message bytes enter on req_chan, one word per byte; the first byte of a
// message carries msg_start and the total length. Packet bytes leave on
// rsp_chan, each word tagged with packet and message boundaries, the packet
// sequence number and the fragment flag. Bytes that arrive with no message
// open are dropped and produce no output word.
// The maximum packet length is written through csr_write_enable and
// csr_write_data; the user must do so only while the block is idle, which the
// block does not enforce. Reset sets it to 512. The first word for an accepted
// byte passes the sequencer job register and the emitter output register. The
// output runs at one word per cycle while the receiver is ready and bytes keep
// arriving. A byte that continues a packet yields only its data word; a byte
// that opens a packet first yields two sequence header words, and four length
// words more in the first packet of a fragmented message, and input waits
// until its data word is loaded. Reset clears the sequence number and all
// message state and empties the block. When the receiver stalls, the output
// word holds and input stops once the one pending job word is waiting.
module reliable_message_fragmenter import rmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rmf_req_if.sink     req_chan,
   rmf_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic    job_valid;
   logic    job_pop;
   job_type job;

   rmf_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job_pop          (job_pop),
      .job_valid        (job_valid),
      .job              (job)
   );

   rmf_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for reliable_message_fragmenter: directed rows and random messages,
// all predicted word by word. Depends on rmf_pkg, rmf_channels and the RTL.
module tb_top import rmf_pkg::*; ();

   localparam int LONG_HOLD = 200;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS = 17;
   localparam int NUM_PHASES = 6;

   typedef enum {ROW_WORD, ROW_MAX_LEN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_payload_type word;
      logic [15:0] max_len;
      int typed_count;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [15:0] csr_write_data;

   rmf_req_if req_chan();
   rmf_rsp_if rsp_chan();

   reliable_message_fragmenter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic [15:0] frag_max_len;
   logic [15:0] frag_seq;
   logic [31:0] frag_bytes_left;
   logic [15:0] frag_room_left;
   logic frag_split;
   logic frag_pkt_open;

   rsp_payload_type predicted_words[$];
   rsp_payload_type pending_packet_words[$];
   rsp_payload_type typed_words[$];
   stim_row_type directed_rows[$];

   int mismatch_count = 0;
   int hold_requests = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic req_payload_type make_req(input logic [7:0] data, input logic start,
                                                input logic [31:0] len);
      req_payload_type w;
      w.data_byte = data;
      w.msg_start = start;
      w.msg_length = len;
      return w;
   endfunction

   function automatic rsp_payload_type make_rsp(input logic [7:0] data, input logic first,
                                                input logic last, input logic frag,
                                                input logic [15:0] seq, input logic mlast);
      rsp_payload_type w;
      w.out_byte = data;
      w.packet_first = first;
      w.packet_last = last;
      w.fragment_flag = frag;
      w.packet_seq = seq;
      w.message_last = mlast;
      return w;
   endfunction

   function automatic string word_text(input rsp_payload_type w);
      return $sformatf("byte %h first %b last %b frag %b seq %h mlast %b", w.out_byte,
                       w.packet_first, w.packet_last, w.fragment_flag, w.packet_seq,
                       w.message_last);
   endfunction

   function automatic logic [15:0] effective_max_len();
      return (frag_max_len < MIN_PACKET_LEN) ? MIN_PACKET_LEN : frag_max_len;
   endfunction

   function automatic void open_packet_header(input logic with_len, input logic [31:0] total);
      logic [15:0] seq;
      seq = frag_seq;
      predicted_words.push_back(make_rsp(seq[15:8], 1'b1, 1'b0, frag_split, seq, 1'b0));
      predicted_words.push_back(make_rsp(seq[7:0], 1'b0, 1'b0, frag_split, seq, 1'b0));
      if (with_len) begin
         for (int i = 3; i >= 0; i--) begin
            predicted_words.push_back(make_rsp(total[8*i +: 8], 1'b0, 1'b0, 1'b1, seq, 1'b0));
         end
      end
      frag_seq = frag_seq + 16'd1;
      frag_pkt_open = 1'b1;
   endfunction

   // Computes the packet words that one accepted message byte produces.
   function automatic void fragment_byte(input req_payload_type w);
      logic [15:0] eff;
      logic [15:0] seq;
      logic mlast;
      logic plast;
      eff = effective_max_len();
      if (w.msg_start) begin
         frag_bytes_left = w.msg_length;
         frag_pkt_open = 1'b0;
         frag_room_left = '0;
         frag_split = 1'b0;
         if (w.msg_length == 32'd0) return;
         frag_split = w.msg_length > {16'd0, eff - SEQ_HDR_BYTES};
         frag_room_left = frag_split ? eff - FULL_HDR_BYTES : eff - SEQ_HDR_BYTES;
         open_packet_header(frag_split, w.msg_length);
      end else begin
         if (frag_bytes_left == 32'd0) return;
         if (!frag_pkt_open) begin
            frag_room_left = eff - SEQ_HDR_BYTES;
            open_packet_header(1'b0, 32'd0);
         end
      end
      seq = frag_seq - 16'd1;
      frag_bytes_left = frag_bytes_left - 32'd1;
      if (frag_room_left != 16'd0) frag_room_left = frag_room_left - 16'd1;
      mlast = (frag_bytes_left == 32'd0);
      plast = mlast || (frag_room_left == 16'd0);
      predicted_words.push_back(make_rsp(w.data_byte, 1'b0, plast, frag_split, seq, mlast));
      if (plast) begin
         frag_pkt_open = 1'b0;
         frag_room_left = '0;
      end
      if (mlast) frag_split = 1'b0;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic offer_word(input req_payload_type w);
      int gap;
      gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         req_chan.payload = make_req(8'($urandom), 1'($urandom), $urandom);
      end
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.payload = w;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_item(input req_payload_type w);
      offer_word(w);
      predicted_words.delete();
      fragment_byte(w);
      foreach (predicted_words[i]) pending_packet_words.push_back(predicted_words[i]);
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_packet_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_max_length(input logic [15:0] value);
      drain_block();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      frag_max_len = value;
   endtask

   task automatic add_word(input logic [7:0] data, input logic start, input logic [31:0] len,
                           input int typed_count);
      stim_row_type row;
      row.kind = ROW_WORD;
      row.word = make_req(data, start, len);
      row.max_len = '0;
      row.typed_count = typed_count;
      directed_rows.push_back(row);
   endtask

   task automatic add_max_len(input logic [15:0] value);
      stim_row_type row;
      row.kind = ROW_MAX_LEN;
      row.word = make_req(8'd0, 1'b0, 32'd0);
      row.max_len = value;
      row.typed_count = 0;
      directed_rows.push_back(row);
   endtask

   task automatic check_packet_word(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_packet_words.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected word, expected none, got %s", $time, word_text(got));
         return;
      end
      want = pending_packet_words.pop_front();
      if (got.out_byte !== want.out_byte || got.packet_first !== want.packet_first ||
          got.packet_last !== want.packet_last || got.fragment_flag !== want.fragment_flag ||
          got.packet_seq !== want.packet_seq || got.message_last !== want.message_last) begin
         mismatch_count++;
         $display("%0t: word mismatch, expected %s, got %s", $time, word_text(want),
                  word_text(got));
      end
   endtask

   initial begin : rsp_sink
      int hold_left;
      int stall_left;
      int holds_seen;
      hold_left = 0;
      stall_left = 0;
      holds_seen = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_packet_word(rsp_chan.payload);
         @(negedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      logic [31:0] len;
      int count;
      int sent;
      int pick;
      int len_cap;
      logic [15:0] phase_max;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = make_req(8'd0, 1'b0, 32'd0);
      frag_max_len = MAX_LEN_RESET;
      frag_seq = '0;
      frag_bytes_left = '0;
      frag_room_left = '0;
      frag_split = 1'b0;
      frag_pkt_open = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_word(8'hFF, 1'b0, 32'hFFFF_FFFF, 0);
      add_word(8'h00, 1'b1, 32'd1, 3);
      typed_words.push_back(make_rsp(8'h00, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0));
      typed_words.push_back(make_rsp(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
      typed_words.push_back(make_rsp(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b1));
      add_word(8'h3C, 1'b1, 32'd0, 0);
      add_word(8'hFF, 1'b0, 32'd0, 0);
      add_word(8'hA5, 1'b1, 32'd3, -1);
      add_word(8'h5A, 1'b0, 32'd0, -1);
      add_word(8'h11, 1'b1, 32'd2, -1);
      add_word(8'hEE, 1'b0, 32'd0, -1);
      add_max_len(16'd0);
      add_word(8'h81, 1'b1, 32'd6, -1);
      add_word(8'h01, 1'b0, 32'd0, -1);
      add_word(8'h02, 1'b0, 32'd0, -1);
      add_word(8'h40, 1'b0, 32'd0, -1);
      add_word(8'h80, 1'b0, 32'd0, -1);
      add_word(8'hFE, 1'b0, 32'd0, -1);
      add_word(8'h99, 1'b0, 32'd0, -1);
      add_max_len(16'd7);
      add_word(8'h42, 1'b1, 32'd5, -1);
      add_word(8'h13, 1'b0, 32'd0, -1);
      add_word(8'h57, 1'b0, 32'd0, -1);
      add_word(8'h9B, 1'b0, 32'd0, -1);
      add_word(8'hDF, 1'b0, 32'd0, -1);
      add_word(8'h24, 1'b1, 32'd6, -1);
      add_word(8'h00, 1'b1, 32'hFFFF_FFFF, -1);
      add_max_len(16'hFFFF);
      add_word(8'h7E, 1'b0, 32'd0, -1);
      add_word(8'h55, 1'b1, 32'h8000_0000, -1);
      add_word(8'h66, 1'b1, 32'd65533, -1);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_MAX_LEN) begin
            set_max_length(row.max_len);
         end else if (row.typed_count < 0) begin
            send_item(row.word);
         end else begin
            offer_word(row.word);
            predicted_words.delete();
            fragment_byte(row.word);
            repeat (row.typed_count) pending_packet_words.push_back(typed_words.pop_front());
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: phase_max = 16'($urandom_range(0, 6));
            1: phase_max = 16'd7;
            2: phase_max = 16'($urandom_range(8, 24));
            3: phase_max = 16'hFFFF;
            4: phase_max = 16'($urandom_range(25, 600));
            default: phase_max = 16'd7;
         endcase
         set_max_length(phase_max);
         tx_idle_on = (phase % 3 != 1);
         rx_idle_on = (phase % 2 == 0);
         if (phase == 1 || phase == 4) hold_requests++;
         len_cap = 3 * int'(effective_max_len());
         if (len_cap > 40) len_cap = 40;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               send_item(make_req(8'($urandom), 1'b0, $urandom));
               sent++;
            end else if (pick == 1) begin
               send_item(make_req(8'($urandom), 1'b1, 32'd0));
               sent++;
            end else begin
               if (pick == 2) begin
                  len = $urandom();
                  if (len == 32'd0) len = 32'd1;
                  count = $urandom_range(1, 12);
                  if (count > len) count = len;
               end else begin
                  len = $urandom_range(1, len_cap);
                  count = len;
                  if ($urandom_range(0, 7) == 0) count = $urandom_range(1, len);
               end
               if (count > PHASE_ITEMS - sent) count = PHASE_ITEMS - sent;
               send_item(make_req(8'($urandom), 1'b1, len));
               for (int k = 1; k < count; k++) begin
                  send_item(make_req(8'($urandom), 1'b0, $urandom));
               end
               sent += count;
            end
         end
      end

      drain_block();
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
